// ----- rtl/core/cpr_pkg.sv -----
// Shared constants and result type for the clock page replacement block.
`default_nettype none

package cpr_pkg;

    localparam int PAGE_COUNT_DEF  = 128;
    localparam int FRAME_COUNT_DEF = 64;

    localparam int PAGE_IN_W     = 7;
    localparam int PAGE_IN_DEPTH = 2 ** PAGE_IN_W;
    localparam int FRAME_OUT_W   = 6;
    localparam int EV_PAGE_W     = 7;
    localparam int HIT_W         = 20;
    localparam int CFG_W         = 7;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
    localparam logic [HIT_W-1:0] HIT_MAX   = {HIT_W{1'b1}};

    localparam int S_DATA_W = 8;
    localparam int RES_W    = 1 + FRAME_OUT_W + 1 + EV_PAGE_W + HIT_W;
    localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

    typedef struct packed {
        logic [HIT_W-1:0]       hit_count;
        logic [EV_PAGE_W-1:0]   evicted_page;
        logic                   evicted_valid;
        logic [FRAME_OUT_W-1:0] frame;
        logic                   hit;
    } cpr_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/cpr_page_table.sv -----
// Page table memory: present bit and frame number per page, registered read.
`default_nettype none

module cpr_page_table #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 7
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/cpr_frame_table.sv -----
// Frame table memory: referenced bit and resident page per frame, separate lane writes.
`default_nettype none

module cpr_frame_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int PW    = 7
) (
    input  wire logic          aclk,
    input  wire logic          ref_we,
    input  wire logic          page_we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic          wref,
    input  wire logic [PW-1:0] wpage,
    input  wire logic [AW-1:0] raddr,
    output logic               rref,
    output logic      [PW-1:0] rpage
);

    logic          ref_mem  [DEPTH];
    logic [PW-1:0] page_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (ref_we) begin
            ref_mem[waddr] <= wref;
        end
        if (page_we) begin
            page_mem[waddr] <= wpage;
        end
        rref  <= ref_mem[raddr];
        rpage <= page_mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/cpr_ctrl.sv -----
// Sequencer: reset clear, lookup, free-frame fill, clock scan, eviction and hit counting.
`default_nettype none

module cpr_ctrl #(
    parameter int PAGE_COUNT  = 128,
    parameter int FRAME_COUNT = 64,
    parameter int PAGE_W      = 7,
    parameter int FRAME_W     = 6
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [cpr_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [cpr_pkg::PAGE_IN_W-1:0] in_page,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output cpr_pkg::cpr_result_t              res,
    output logic                              pt_we,
    output logic      [PAGE_W-1:0]            pt_waddr,
    output logic      [FRAME_W:0]             pt_wdata,
    output logic      [PAGE_W-1:0]            pt_raddr,
    input  wire logic [FRAME_W:0]             pt_rdata,
    output logic                              ft_ref_we,
    output logic                              ft_page_we,
    output logic      [FRAME_W-1:0]           ft_waddr,
    output logic                              ft_wref,
    output logic      [PAGE_W-1:0]            ft_wpage,
    output logic      [FRAME_W-1:0]           ft_raddr,
    input  wire logic                         ft_rref,
    input  wire logic [PAGE_W-1:0]            ft_rpage
);

    import cpr_pkg::*;

    localparam int NW = FRAME_W + 1;
    localparam int LW = (NW > CFG_W) ? NW : CFG_W;
    localparam logic [PAGE_W-1:0] CLR_LAST = PAGE_W'(PAGE_COUNT - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOOK  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_EVICT = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [PAGE_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [PAGE_W-1:0]  pg_reg, pg_next;
    logic [FRAME_W-1:0] h_reg, h_next;
    logic [NW-1:0]      steps_reg, steps_next;
    logic [FRAME_W-1:0] hand_reg, hand_next;
    logic [NW-1:0]      filled_reg, filled_next;
    logic [HIT_W-1:0]   hit_total_reg, hit_total_next;
    logic [CFG_W-1:0]   cfg_reg, cfg_next;
    logic               res_hit_reg, res_hit_next;
    logic [FRAME_W-1:0] res_frame_reg, res_frame_next;
    logic               res_ev_reg, res_ev_next;
    logic [PAGE_W-1:0]  res_evpage_reg, res_evpage_next;

    logic [PAGE_W-1:0]  mod_tab [PAGE_IN_DEPTH];
    logic [PAGE_W-1:0]  pg_in;
    logic [LW-1:0]      limit;
    logic [NW-1:0]      h_inc;
    logic [FRAME_W-1:0] h_wrap;
    logic [FRAME_W-1:0] h_start;

    // constant reduction of the input page number
    for (genvar i = 0; i < PAGE_IN_DEPTH; i++) begin : g_mod
        assign mod_tab[i] = PAGE_W'(i % PAGE_COUNT);
    end

    assign pg_in = mod_tab[in_page];

    always_comb begin
        if (cfg_reg == '0) begin
            limit = LW'(1);
        end else if (LW'(cfg_reg) > LW'(FRAME_COUNT)) begin
            limit = LW'(FRAME_COUNT);
        end else begin
            limit = LW'(cfg_reg);
        end
    end

    assign h_inc   = {1'b0, h_reg} + NW'(1);
    assign h_wrap  = (h_inc < filled_reg) ? h_inc[FRAME_W-1:0] : '0;
    assign h_start = ({1'b0, hand_reg} >= filled_reg) ? '0 : hand_reg;

    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        pg_next         = pg_reg;
        h_next          = h_reg;
        steps_next      = steps_reg;
        hand_next       = hand_reg;
        filled_next     = filled_reg;
        hit_total_next  = hit_total_reg;
        cfg_next        = cfg_reg;
        res_hit_next    = res_hit_reg;
        res_frame_next  = res_frame_reg;
        res_ev_next     = res_ev_reg;
        res_evpage_next = res_evpage_reg;
        pt_we           = 1'b0;
        pt_waddr        = pg_reg;
        pt_wdata        = '0;
        pt_raddr        = pg_in;
        ft_ref_we       = 1'b0;
        ft_page_we      = 1'b0;
        ft_waddr        = h_reg;
        ft_wref         = 1'b0;
        ft_wpage        = pg_reg;
        ft_raddr        = h_wrap;
        res_valid       = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                pt_we         = 1'b1;
                pt_waddr      = clr_addr_reg;
                clr_addr_next = clr_addr_reg + PAGE_W'(1);
                if (clr_addr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    pg_next    = pg_in;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                res_ev_next     = 1'b0;
                res_evpage_next = '0;
                if (pt_rdata[FRAME_W]) begin
                    // hit: mark the frame referenced
                    ft_ref_we      = 1'b1;
                    ft_waddr       = pt_rdata[FRAME_W-1:0];
                    ft_wref        = 1'b1;
                    res_hit_next   = 1'b1;
                    res_frame_next = pt_rdata[FRAME_W-1:0];
                    if (hit_total_reg != HIT_MAX) begin
                        hit_total_next = hit_total_reg + HIT_W'(1);
                    end
                    state_next = ST_DONE;
                end else if (LW'(filled_reg) < limit) begin
                    // fill the next free frame
                    ft_ref_we      = 1'b1;
                    ft_page_we     = 1'b1;
                    ft_waddr       = filled_reg[FRAME_W-1:0];
                    pt_we          = 1'b1;
                    pt_wdata       = {1'b1, filled_reg[FRAME_W-1:0]};
                    filled_next    = filled_reg + NW'(1);
                    res_hit_next   = 1'b0;
                    res_frame_next = filled_reg[FRAME_W-1:0];
                    state_next     = ST_DONE;
                end else begin
                    h_next     = h_start;
                    steps_next = '0;
                    ft_raddr   = h_start;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (ft_rref && (steps_reg < filled_reg)) begin
                    // second chance: clear and advance
                    ft_ref_we  = 1'b1;
                    h_next     = h_wrap;
                    steps_next = steps_reg + NW'(1);
                end else begin
                    ft_ref_we       = 1'b1;
                    ft_page_we      = 1'b1;
                    pt_we           = 1'b1;
                    pt_waddr        = ft_rpage;
                    hand_next       = h_wrap;
                    res_hit_next    = 1'b0;
                    res_frame_next  = h_reg;
                    res_ev_next     = 1'b1;
                    res_evpage_next = ft_rpage;
                    state_next      = ST_EVICT;
                end
            end
            ST_EVICT: begin
                pt_we      = 1'b1;
                pt_wdata   = {1'b1, h_reg};
                state_next = ST_DONE;
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we) begin
            cfg_next = cfg_data;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    assign res.hit           = res_hit_reg;
    assign res.frame         = FRAME_OUT_W'(res_frame_reg);
    assign res.evicted_valid = res_ev_reg;
    assign res.evicted_page  = EV_PAGE_W'(res_evpage_reg);
    assign res.hit_count     = hit_total_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            hand_reg      <= '0;
            filled_reg    <= '0;
            hit_total_reg <= '0;
            cfg_reg       <= CFG_RESET;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            hand_reg      <= hand_next;
            filled_reg    <= filled_next;
            hit_total_reg <= hit_total_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge aclk) begin
        pg_reg         <= pg_next;
        h_reg          <= h_next;
        steps_reg      <= steps_next;
        res_hit_reg    <= res_hit_next;
        res_frame_reg  <= res_frame_next;
        res_ev_reg     <= res_ev_next;
        res_evpage_reg <= res_evpage_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/clock_page_replacement.sv -----
// Clock (second chance) page replacement: top level with output register.
// A hit or a free-frame fill goes from the lookup state straight to the done state;
// an eviction first runs the clock scan, which passes the k referenced frames (0..filled),
// and then the evict state. A new page is taken only once the last result has gone to the
// output register; the clock scan reads one frame table entry per cycle.
// Reset: a clearing pass writes the page table, one entry a cycle over all PAGE_COUNT entries
// (128 by default) with s_tready low; configuration writes are taken meanwhile.
`default_nettype none

module clock_page_replacement #(
    parameter int PAGE_COUNT  = cpr_pkg::PAGE_COUNT_DEF,
    parameter int FRAME_COUNT = cpr_pkg::FRAME_COUNT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [cpr_pkg::CFG_W-1:0]     cfg_wr_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [6:0] page, [7] zero
    input  wire logic [cpr_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [0] hit, [6:1] frame, [7] evicted_valid, [14:8] evicted_page,
    // [34:15] hit_count, [39:35] zero
    output logic      [cpr_pkg::M_DATA_W-1:0]  m_tdata
);

    import cpr_pkg::*;

    localparam int PAGE_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int FRAME_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;

    logic               res_valid;
    logic               res_ready;
    cpr_result_t        res;
    cpr_result_t        out_reg;
    logic               out_valid_reg;

    logic               pt_we;
    logic [PAGE_W-1:0]  pt_waddr;
    logic [FRAME_W:0]   pt_wdata;
    logic [PAGE_W-1:0]  pt_raddr;
    logic [FRAME_W:0]   pt_rdata;
    logic               ft_ref_we;
    logic               ft_page_we;
    logic [FRAME_W-1:0] ft_waddr;
    logic               ft_wref;
    logic [PAGE_W-1:0]  ft_wpage;
    logic [FRAME_W-1:0] ft_raddr;
    logic               ft_rref;
    logic [PAGE_W-1:0]  ft_rpage;

    cpr_ctrl #(
        .PAGE_COUNT (PAGE_COUNT),
        .FRAME_COUNT(FRAME_COUNT),
        .PAGE_W     (PAGE_W),
        .FRAME_W    (FRAME_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_wr_en),
        .cfg_data  (cfg_wr_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_page   (s_tdata[PAGE_IN_W-1:0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .pt_we     (pt_we),
        .pt_waddr  (pt_waddr),
        .pt_wdata  (pt_wdata),
        .pt_raddr  (pt_raddr),
        .pt_rdata  (pt_rdata),
        .ft_ref_we (ft_ref_we),
        .ft_page_we(ft_page_we),
        .ft_waddr  (ft_waddr),
        .ft_wref   (ft_wref),
        .ft_wpage  (ft_wpage),
        .ft_raddr  (ft_raddr),
        .ft_rref   (ft_rref),
        .ft_rpage  (ft_rpage)
    );

    cpr_page_table #(
        .DEPTH(PAGE_COUNT),
        .AW   (PAGE_W),
        .DW   (FRAME_W + 1)
    ) u_page_table (
        .aclk (aclk),
        .we   (pt_we),
        .waddr(pt_waddr),
        .wdata(pt_wdata),
        .raddr(pt_raddr),
        .rdata(pt_rdata)
    );

    cpr_frame_table #(
        .DEPTH(FRAME_COUNT),
        .AW   (FRAME_W),
        .PW   (PAGE_W)
    ) u_frame_table (
        .aclk   (aclk),
        .ref_we (ft_ref_we),
        .page_we(ft_page_we),
        .waddr  (ft_waddr),
        .wref   (ft_wref),
        .wpage  (ft_wpage),
        .raddr  (ft_raddr),
        .rref   (ft_rref),
        .rpage  (ft_rpage)
    );

    // output register decouples the result from the next lookup
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - RES_W){1'b0}}, out_reg};

endmodule

`default_nettype wire
